@@ sv/pfde_pkg.sv @@
// pfde_pkg: shared types and constants of the page framebuffer draw engine
// command codes, default geometry, controller/datapath command and status structs
// no dependencies
package pfde_pkg;

    localparam int DEF_WIDTH_PIXELS  = 128;
    localparam int DEF_HEIGHT_PIXELS = 64;
    localparam int DEF_PAGE_COUNT    = 8;

    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] BYTE_ZEROS = 8'h00;

    typedef enum logic [2:0] {
        CMD_VISUAL_PIXEL = 3'd0,
        CMD_NATIVE_PIXEL = 3'd1,
        CMD_CLEAR_RECT   = 3'd2,
        CMD_BLIT_BYTE    = 3'd3,
        CMD_FILL         = 3'd4,
        CMD_CLEAR        = 3'd5,
        CMD_READ_BYTE    = 3'd6
    } cmd_code_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic commit;
        logic walk_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_go;
        logic walk_last;
    } dp_status_t;

endpackage

@@ sv/pfde_cmd_if.sv @@
// pfde_cmd_if: command channel of the draw engine
// valid/ready handshake with the command fields; no dependencies
interface pfde_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        cmd;
    logic signed [8:0] x;
    logic signed [7:0] y;
    logic signed [4:0] page;
    logic [3:0]        bit_req;
    logic              on;
    logic [7:0]        width;
    logic [3:0]        pages;
    logic [7:0]        data;
    logic              first;

    modport source (
        output valid, cmd, x, y, page, bit_req, on, width, pages, data, first,
        input  ready
    );
    modport sink (
        input  valid, cmd, x, y, page, bit_req, on, width, pages, data, first,
        output ready
    );
endinterface

@@ sv/pfde_rsp_if.sv @@
// pfde_rsp_if: result channel of the draw engine
// valid/ready handshake with read data and status; no dependencies
interface pfde_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       status;

    modport source (
        output valid, read_data, status,
        input  ready
    );
    modport sink (
        input  valid, read_data, status,
        output ready
    );
endinterface

@@ sv/pfde_ctrl.sv @@
// pfde_ctrl: controller state machine of the draw engine
// sequences capture, execute, walk and commit; uses pfde_pkg
module pfde_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  pfde_pkg::dp_status_t  dp_status,
    output pfde_pkg::ctrl_cmd_t   ctl
);
    import pfde_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_WRITE = 4'b0100,
        S_WALK  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   boot_reg, boot_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctl        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        boot_next  = boot_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = dp_status.walk_go ? S_WALK : S_WRITE;
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    in_ready   = 1'b1;
                    ctl.commit = 1'b1;
                    if (in_valid)
                    begin
                        ctl.capture = 1'b1;
                        state_next  = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WALK:
            begin
                ctl.walk_step = 1'b1;
                if (dp_status.walk_last)
                begin
                    if (boot_reg)
                    begin
                        boot_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = ctl.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // reset starts in the walk state to sweep the store clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_WALK;
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            boot_reg      <= boot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_exec_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> (state_reg == S_WALK || state_reg == S_WRITE))
        else $error("exec not followed by walk or write");

    a_boot_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        boot_reg |-> (state_reg == S_WALK && !out_valid_reg))
        else $error("activity during clearing pass");

    a_rose_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_WRITE))
        else $error("result without commit");

    a_walk_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && !dp_status.walk_last) |=> (state_reg == S_WALK))
        else $error("walk left early");

endmodule

@@ sv/pfde_datapath.sv @@
// pfde_datapath: frame store, blit cursor, walk counters and result registers
// address and clip logic per command; uses pfde_pkg
module pfde_datapath #(
    parameter int WIDTH_PIXELS  = pfde_pkg::DEF_WIDTH_PIXELS,
    parameter int HEIGHT_PIXELS = pfde_pkg::DEF_HEIGHT_PIXELS,
    parameter int PAGE_COUNT    = pfde_pkg::DEF_PAGE_COUNT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfde_pkg::ctrl_cmd_t  ctl,
    output pfde_pkg::dp_status_t dp_status,
    input  logic [2:0]           cmd,
    input  logic signed [8:0]    x,
    input  logic signed [7:0]    y,
    input  logic signed [4:0]    page,
    input  logic [3:0]           bit_req,
    input  logic                 on,
    input  logic [7:0]           width,
    input  logic [3:0]           pages,
    input  logic [7:0]           data,
    input  logic                 first,
    output logic [7:0]           read_data,
    output logic                 status
);
    import pfde_pkg::*;

    localparam int CW    = $clog2(WIDTH_PIXELS);
    localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int DEPTH = WIDTH_PIXELS * PAGE_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int AW1   = AW + 1;

    localparam logic signed [10:0] W_S = 11'(WIDTH_PIXELS);
    localparam logic signed [6:0]  P_S = 7'(PAGE_COUNT);
    localparam logic signed [8:0]  H_S = 9'(HEIGHT_PIXELS);

    function automatic logic [AW-1:0] addr_of(logic [PW-1:0] p, logic [CW-1:0] c);
        logic [AW:0] sum;
        sum = AW1'(p) * AW1'(WIDTH_PIXELS) + AW1'(c);
        return sum[AW-1:0];
    endfunction

    function automatic logic col_in(logic signed [10:0] v);
        return (v >= 11'sd0) && (v < W_S);
    endfunction

    function automatic logic page_in(logic signed [6:0] v);
        return (v >= 7'sd0) && (v < P_S);
    endfunction

    logic [7:0] mem [DEPTH];
    logic [7:0] mem_q_reg;

    logic [2:0]        cmd_reg;
    logic signed [8:0] x_reg;
    logic signed [7:0] y_reg;
    logic signed [4:0] page_reg;
    logic [3:0]        bit_reg;
    logic              on_reg;
    logic [7:0]        width_reg;
    logic [3:0]        pages_reg;
    logic [7:0]        data_reg;
    logic              first_reg;

    logic [7:0] blit_column_reg, blit_column_next;
    logic [3:0] blit_row_reg, blit_row_next;

    logic [CW-1:0] walk_col_reg, col_lo_reg, col_hi_reg;
    logic [PW-1:0] walk_page_reg, page_hi_reg;
    logic [7:0]    walk_value_reg;

    logic          wr_en_reg, wr_blit_reg, wr_on_reg, status_reg, read_sel_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [7:0]    wr_mask_reg, wr_data_reg;
    logic [7:0]    read_data_reg;
    logic          status_out_reg;

    logic              ex_wr_en, ex_blit, ex_status, ex_read_sel, ex_walk_go;
    logic [CW-1:0]     ex_col, ex_col_lo, ex_col_hi;
    logic [PW-1:0]     ex_page, ex_page_lo, ex_page_hi;
    logic [7:0]        ex_mask, ex_walk_value;
    logic [AW-1:0]     ex_addr, walk_addr, mem_waddr;
    logic [7:0]        mem_wdata, pix_new;
    logic              mem_we;

    logic signed [10:0] xs, x0, x1, x1c, xl, dc;
    logic signed [6:0]  ps, p0, p1, p1c, pl, dp;
    logic signed [8:0]  ys;
    logic [7:0]         cur_col;
    logic [3:0]         cur_row;
    logic [8:0]         col_inc, col_mirror;
    logic [4:0]         row_inc;
    logic [6:0]         ny;
    logic               rect_empty;

    always_comb
    begin
        xs  = {{2{x_reg[8]}}, x_reg};
        ps  = {{2{page_reg[4]}}, page_reg};
        ys  = {y_reg[7], y_reg};
        x0  = xs[10] ? 11'sd0 : xs;
        x1  = xs + $signed({3'b000, width_reg});
        x1c = (x1 > W_S) ? W_S : x1;
        xl  = x1c - 11'sd1;
        p0  = ps[6] ? 7'sd0 : ps;
        p1  = ps + $signed({3'b000, pages_reg});
        p1c = (p1 > P_S) ? P_S : p1;
        pl  = p1c - 7'sd1;
        rect_empty = (x0 >= x1c) || (p0 >= p1c);

        cur_col = first_reg ? 8'd0 : blit_column_reg;
        cur_row = first_reg ? 4'd0 : blit_row_reg;
        dc      = xs + $signed({3'b000, cur_col});
        dp      = ps + $signed({3'b000, cur_row});
        col_inc = {1'b0, cur_col} + 9'd1;
        row_inc = {1'b0, cur_row} + 5'd1;

        col_mirror = 9'(WIDTH_PIXELS - 1) - {1'b0, x_reg[7:0]};
        ny         = 7'(HEIGHT_PIXELS - 1) - ys[6:0];

        ex_wr_en      = 1'b0;
        ex_blit       = 1'b0;
        ex_status     = 1'b0;
        ex_read_sel   = 1'b0;
        ex_walk_go    = 1'b0;
        ex_col        = xs[CW-1:0];
        ex_page       = ps[PW-1:0];
        ex_mask       = 8'd1 << bit_reg[2:0];
        ex_col_lo     = '0;
        ex_col_hi     = CW'(WIDTH_PIXELS - 1);
        ex_page_lo    = '0;
        ex_page_hi    = PW'(PAGE_COUNT - 1);
        ex_walk_value = BYTE_ZEROS;
        blit_column_next = blit_column_reg;
        blit_row_next    = blit_row_reg;

        case (cmd_reg)
            CMD_VISUAL_PIXEL:
            begin
                ex_col  = col_mirror[CW-1:0];
                ex_page = PW'(ny[6:3]);
                ex_mask = 8'd1 << ny[2:0];
                if (!(col_in(xs) && ys >= 9'sd0 && ys < H_S))
                    ex_status = 1'b1;
                else if ({1'b0, ny[6:3]} >= 5'(PAGE_COUNT))
                    ex_status = 1'b1;
                else
                    ex_wr_en = 1'b1;
            end
            CMD_NATIVE_PIXEL:
            begin
                if (col_in(xs) && page_in(ps) && !bit_reg[3])
                    ex_wr_en = 1'b1;
                else
                    ex_status = 1'b1;
            end
            CMD_CLEAR_RECT:
            begin
                ex_col_lo  = x0[CW-1:0];
                ex_col_hi  = xl[CW-1:0];
                ex_page_lo = p0[PW-1:0];
                ex_page_hi = pl[PW-1:0];
                if (width_reg == 8'd0 || pages_reg == 4'd0 || rect_empty)
                    ex_status = 1'b1;
                else
                    ex_walk_go = 1'b1;
            end
            CMD_BLIT_BYTE:
            begin
                ex_col           = dc[CW-1:0];
                ex_page          = dp[PW-1:0];
                ex_blit          = 1'b1;
                blit_column_next = cur_col;
                blit_row_next    = cur_row;
                if (width_reg == 8'd0 || pages_reg == 4'd0)
                begin
                    ex_status = 1'b1;
                end
                else
                begin
                    if (col_in(dc) && page_in(dp))
                        ex_wr_en = 1'b1;
                    else
                        ex_status = 1'b1;
                    if (col_inc >= {1'b0, width_reg})
                    begin
                        blit_column_next = 8'd0;
                        blit_row_next = (row_inc >= {1'b0, pages_reg}) ? 4'd0 : row_inc[3:0];
                    end
                    else
                    begin
                        blit_column_next = col_inc[7:0];
                    end
                end
            end
            CMD_FILL:
            begin
                ex_walk_go    = 1'b1;
                ex_walk_value = BYTE_ONES;
            end
            CMD_CLEAR:
            begin
                ex_walk_go = 1'b1;
            end
            CMD_READ_BYTE:
            begin
                if (col_in(xs) && page_in(ps))
                    ex_read_sel = 1'b1;
                else
                    ex_status = 1'b1;
            end
            default:
            begin
                ex_status = 1'b1;
            end
        endcase
    end

    assign ex_addr   = addr_of(ex_page, ex_col);
    assign walk_addr = addr_of(walk_page_reg, walk_col_reg);

    assign dp_status.walk_go   = ex_walk_go;
    assign dp_status.walk_last = (walk_col_reg == col_hi_reg) && (walk_page_reg == page_hi_reg);

    // read-modify-write of one byte; a blit writes its data byte whole
    assign pix_new = wr_blit_reg ? wr_data_reg
                   : (wr_on_reg ? (mem_q_reg | wr_mask_reg) : (mem_q_reg & ~wr_mask_reg));

    assign mem_we    = ctl.walk_step || (ctl.commit && wr_en_reg);
    assign mem_waddr = ctl.walk_step ? walk_addr : wr_addr_reg;
    assign mem_wdata = ctl.walk_step ? walk_value_reg : pix_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (ctl.exec)
            mem_q_reg <= mem[ex_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= cmd;
            x_reg     <= x;
            y_reg     <= y;
            page_reg  <= page;
            bit_reg   <= bit_req;
            on_reg    <= on;
            width_reg <= width;
            pages_reg <= pages;
            data_reg  <= data;
            first_reg <= first;
        end
        if (ctl.exec)
        begin
            wr_en_reg    <= ex_wr_en;
            wr_blit_reg  <= ex_blit;
            wr_on_reg    <= on_reg;
            wr_addr_reg  <= ex_addr;
            wr_mask_reg  <= ex_mask;
            wr_data_reg  <= data_reg;
            status_reg   <= ex_status;
            read_sel_reg <= ex_read_sel;
        end
        if (ctl.commit)
        begin
            read_data_reg  <= read_sel_reg ? mem_q_reg : BYTE_ZEROS;
            status_out_reg <= status_reg;
        end
    end

    // walk registers reset to a full-store clear for the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blit_column_reg <= 8'd0;
            blit_row_reg    <= 4'd0;
            walk_col_reg    <= '0;
            walk_page_reg   <= '0;
            col_lo_reg      <= '0;
            col_hi_reg      <= CW'(WIDTH_PIXELS - 1);
            page_hi_reg     <= PW'(PAGE_COUNT - 1);
            walk_value_reg  <= BYTE_ZEROS;
        end
        else if (ctl.exec)
        begin
            blit_column_reg <= blit_column_next;
            blit_row_reg    <= blit_row_next;
            walk_col_reg    <= ex_col_lo;
            walk_page_reg   <= ex_page_lo;
            col_lo_reg      <= ex_col_lo;
            col_hi_reg      <= ex_col_hi;
            page_hi_reg     <= ex_page_hi;
            walk_value_reg  <= ex_walk_value;
        end
        else if (ctl.walk_step)
        begin
            if (walk_col_reg == col_hi_reg)
            begin
                walk_col_reg  <= col_lo_reg;
                walk_page_reg <= walk_page_reg + PW'(1);
            end
            else
            begin
                walk_col_reg <= walk_col_reg + CW'(1);
            end
        end
    end

    assign read_data = read_data_reg;
    assign status    = status_out_reg;

endmodule

@@ sv/page_framebuffer_draw_engine.sv @@
// page_framebuffer_draw_engine: top level of the page framebuffer draw engine
// joins pfde_ctrl and pfde_datapath; uses pfde_pkg, pfde_cmd_if, pfde_rsp_if
//
//   channel   dir   interface     payload
//   command   in    pfde_cmd_if   cmd x y page bit_req on width pages data first
//   result    out   pfde_rsp_if   read_data status
//
// pixel, blit, read and ignored commands: the execute state reads the store byte and
// the commit state writes it back; the next command can be taken in the commit state
// clear rect, fill and clear: a walk of the area, one store byte written per cycle
// reset: clearing pass over all WIDTH_PIXELS * PAGE_COUNT bytes before the first transaction
// a finished result waits in the output register while the next command is taken
module page_framebuffer_draw_engine #(
    parameter int WIDTH_PIXELS  = pfde_pkg::DEF_WIDTH_PIXELS,
    parameter int HEIGHT_PIXELS = pfde_pkg::DEF_HEIGHT_PIXELS,
    parameter int PAGE_COUNT    = pfde_pkg::DEF_PAGE_COUNT
) (
    input logic        clk,
    input logic        rst_n,
    pfde_cmd_if.sink   command,
    pfde_rsp_if.source result
);
    import pfde_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t dp_status;

    pfde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (command.valid),
        .in_ready  (command.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .dp_status (dp_status),
        .ctl       (ctl)
    );

    pfde_datapath #(
        .WIDTH_PIXELS  (WIDTH_PIXELS),
        .HEIGHT_PIXELS (HEIGHT_PIXELS),
        .PAGE_COUNT    (PAGE_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .dp_status (dp_status),
        .cmd       (command.cmd),
        .x         (command.x),
        .y         (command.y),
        .page      (command.page),
        .bit_req   (command.bit_req),
        .on        (command.on),
        .width     (command.width),
        .pages     (command.pages),
        .data      (command.data),
        .first     (command.first),
        .read_data (result.read_data),
        .status    (result.status)
    );

endmodule

@@ tb/sv/page_framebuffer_draw_engine_test.sv @@
`timescale 1ns / 100ps
// page_framebuffer_draw_engine_test: self-checking testbench of the page framebuffer draw engine
// keeps its own framebuffer image to predict each result, drives directed and random commands
// depends on pfde_pkg, pfde_cmd_if, pfde_rsp_if and page_framebuffer_draw_engine
module page_framebuffer_draw_engine_test;
    import pfde_pkg::*;

    localparam int SCREEN_W       = DEF_WIDTH_PIXELS;
    localparam int SCREEN_H       = DEF_HEIGHT_PIXELS;
    localparam int SCREEN_PAGES   = DEF_PAGE_COUNT;
    localparam int STORE_BYTES    = SCREEN_W * SCREEN_PAGES;
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int RESET_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 50;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic [2:0]        cmd;
        logic signed [8:0] x;
        logic signed [7:0] y;
        logic signed [4:0] page;
        logic [3:0]        bit_req;
        logic              on;
        logic [7:0]        width;
        logic [3:0]        pages;
        logic [7:0]        data;
        logic              first;
    } draw_cmd_t;

    typedef struct {
        logic [7:0] read_data;
        logic       status;
    } draw_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pfde_cmd_if cmd_if ();
    pfde_rsp_if rsp_if ();

    page_framebuffer_draw_engine u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (cmd_if),
        .result  (rsp_if)
    );

    logic [7:0] pixel_store [STORE_BYTES];
    int         blit_col;
    int         blit_row;
    draw_rsp_t  pending_results [$];
    draw_rsp_t  expected_rsp;
    int         items_sent = 0;
    int         error_count = 0;
    int         stall_cycles = 0;
    int         cmd_idle_pct = 36;
    int         rsp_idle_pct = 36;
    logic       hold_request = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic on_screen(input int col, input int pg);
        return col >= 0 && col < SCREEN_W && pg >= 0 && pg < SCREEN_PAGES;
    endfunction

    function automatic logic put_pixel(input int col, input int pg, input int bit_idx,
                                       input logic on);
        int addr;
        if (!on_screen(col, pg) || bit_idx > 7)
            return 1'b1;
        addr = pg * SCREEN_W + col;
        if (on)
            pixel_store[addr] = pixel_store[addr] | (8'd1 << bit_idx);
        else
            pixel_store[addr] = pixel_store[addr] & ~(8'd1 << bit_idx);
        return 1'b0;
    endfunction

    // updates the framebuffer image and cursor, returns the result the command must give
    function automatic draw_rsp_t apply_command(input draw_cmd_t c);
        draw_rsp_t r;
        int xs, ys, ps, w, np, ny, x0, x1, p0, p1, dc, dp;
        xs = c.x;
        ys = c.y;
        ps = c.page;
        w  = c.width;
        np = c.pages;
        r.read_data = BYTE_ZEROS;
        r.status    = 1'b0;
        case (c.cmd)
            CMD_VISUAL_PIXEL:
            begin
                if (xs < 0 || xs >= SCREEN_W || ys < 0 || ys >= SCREEN_H)
                    r.status = 1'b1;
                else
                begin
                    ny = SCREEN_H - 1 - ys;
                    r.status = put_pixel(SCREEN_W - 1 - xs, ny / 8, ny % 8, c.on);
                end
            end
            CMD_NATIVE_PIXEL:
                r.status = put_pixel(xs, ps, int'(c.bit_req), c.on);
            CMD_CLEAR_RECT:
            begin
                if (w == 0 || np == 0)
                    r.status = 1'b1;
                else
                begin
                    x0 = xs < 0 ? 0 : xs;
                    p0 = ps < 0 ? 0 : ps;
                    x1 = xs + w > SCREEN_W ? SCREEN_W : xs + w;
                    p1 = ps + np > SCREEN_PAGES ? SCREEN_PAGES : ps + np;
                    if (x0 >= x1 || p0 >= p1)
                        r.status = 1'b1;
                    for (int p = p0; p < p1; p++)
                        for (int col = x0; col < x1; col++)
                            pixel_store[p * SCREEN_W + col] = BYTE_ZEROS;
                end
            end
            CMD_BLIT_BYTE:
            begin
                if (c.first)
                begin
                    blit_col = 0;
                    blit_row = 0;
                end
                if (w == 0 || np == 0)
                    r.status = 1'b1;
                else
                begin
                    dc = xs + blit_col;
                    dp = ps + blit_row;
                    if (on_screen(dc, dp))
                        pixel_store[dp * SCREEN_W + dc] = c.data;
                    else
                        r.status = 1'b1;
                    if (blit_col + 1 >= w)
                    begin
                        blit_col = 0;
                        blit_row = (blit_row + 1 >= np) ? 0 : blit_row + 1;
                    end
                    else
                        blit_col = blit_col + 1;
                end
            end
            CMD_FILL:
                foreach (pixel_store[i])
                    pixel_store[i] = BYTE_ONES;
            CMD_CLEAR:
                foreach (pixel_store[i])
                    pixel_store[i] = BYTE_ZEROS;
            CMD_READ_BYTE:
            begin
                if (on_screen(xs, ps))
                    r.read_data = pixel_store[ps * SCREEN_W + xs];
                else
                    r.status = 1'b1;
            end
            default:
                r.status = 1'b1;
        endcase
        return r;
    endfunction

    function automatic draw_cmd_t random_cmd(input logic [2:0] op);
        draw_cmd_t c;
        c.cmd     = op;
        c.x       = 9'($urandom);
        c.y       = 8'($urandom);
        c.page    = 5'($urandom);
        c.bit_req = 4'($urandom);
        c.on      = 1'($urandom);
        c.width   = 8'($urandom);
        c.pages   = 4'($urandom);
        c.data    = 8'($urandom);
        c.first   = 1'($urandom);
        return c;
    endfunction

    function automatic draw_cmd_t shaped_cmd(input logic [2:0] op, input int xv, input int pv);
        draw_cmd_t c;
        c      = random_cmd(op);
        c.x    = 9'(xv);
        c.page = 5'(pv);
        return c;
    endfunction

    task automatic send_cmd(input draw_cmd_t c);
        while ($urandom_range(99) < cmd_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.cmd     <= c.cmd;
        cmd_if.x       <= c.x;
        cmd_if.y       <= c.y;
        cmd_if.page    <= c.page;
        cmd_if.bit_req <= c.bit_req;
        cmd_if.on      <= c.on;
        cmd_if.width   <= c.width;
        cmd_if.pages   <= c.pages;
        cmd_if.data    <= c.data;
        cmd_if.first   <= c.first;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        pending_results.push_back(apply_command(c));
        items_sent++;
    endtask

    // result sink: random stalls plus a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected transaction: read_data %02h status %0d",
                       rsp_if.read_data, rsp_if.status);
                error_count++;
            end
            else
            begin
                expected_rsp = pending_results.pop_front();
                if (rsp_if.read_data !== expected_rsp.read_data)
                begin
                    $error("read_data mismatch: expected %02h, actual %02h",
                           expected_rsp.read_data, rsp_if.read_data);
                    error_count++;
                end
                if (rsp_if.status !== expected_rsp.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           expected_rsp.status, rsp_if.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_fill_and_read();
        send_cmd(random_cmd(CMD_FILL));
        send_cmd(shaped_cmd(CMD_READ_BYTE, 0, 0));
        send_cmd(random_cmd(CMD_CLEAR));
        send_cmd(shaped_cmd(CMD_READ_BYTE, SCREEN_W - 1, SCREEN_PAGES - 1));
    endtask

    task automatic test_visual_pixels();
        draw_cmd_t c;
        c = shaped_cmd(CMD_VISUAL_PIXEL, 0, 0);
        c.y = 8'd0;
        c.on = 1'b1;
        send_cmd(c);
        c = shaped_cmd(CMD_VISUAL_PIXEL, SCREEN_W - 1, 0);
        c.y = 8'(SCREEN_H - 1);
        c.on = 1'b1;
        send_cmd(c);
        c = shaped_cmd(CMD_VISUAL_PIXEL, -256, 0);
        c.y = 8'(-128);
        send_cmd(c);
        c = shaped_cmd(CMD_VISUAL_PIXEL, 255, 0);
        c.y = 8'd127;
        send_cmd(c);
    endtask

    task automatic test_native_pixels();
        draw_cmd_t c;
        c = shaped_cmd(CMD_NATIVE_PIXEL, SCREEN_W - 1, SCREEN_PAGES - 1);
        c.bit_req = 4'd0;
        c.on = 1'b1;
        send_cmd(c);
        c = shaped_cmd(CMD_NATIVE_PIXEL, 0, 0);
        c.bit_req = 4'd0;
        c.on = 1'b0;
        send_cmd(c);
        c = shaped_cmd(CMD_NATIVE_PIXEL, 255, 15);
        c.bit_req = 4'd15;
        send_cmd(c);
        c = shaped_cmd(CMD_NATIVE_PIXEL, -256, -16);
        c.bit_req = 4'd7;
        send_cmd(c);
        c = shaped_cmd(CMD_NATIVE_PIXEL, 0, SCREEN_PAGES - 1);
        c.bit_req = 4'd8;
        c.on = 1'b1;
        send_cmd(c);
    endtask

    task automatic test_clear_rect();
        draw_cmd_t c;
        c = shaped_cmd(CMD_CLEAR_RECT, 0, 0);
        c.width = 8'd0;
        send_cmd(c);
        c = shaped_cmd(CMD_CLEAR_RECT, 0, 0);
        c.width = 8'd4;
        c.pages = 4'd0;
        send_cmd(c);
        // lands entirely left of the screen
        c = shaped_cmd(CMD_CLEAR_RECT, -256, 0);
        c.width = 8'd255;
        c.pages = 4'd1;
        send_cmd(c);
        c = shaped_cmd(CMD_CLEAR_RECT, -1, -1);
        c.width = 8'd255;
        c.pages = 4'd15;
        send_cmd(c);
    endtask

    task automatic test_blit_stream();
        draw_cmd_t c;
        // 2x2 block at the bottom right corner, half of it off-screen
        for (int k = 0; k < 4; k++)
        begin
            c = shaped_cmd(CMD_BLIT_BYTE, SCREEN_W - 1, SCREEN_PAGES - 2);
            c.width = 8'd2;
            c.pages = 4'd2;
            c.first = (k == 0);
            send_cmd(c);
        end
        c = shaped_cmd(CMD_BLIT_BYTE, 0, 0);
        c.width = 8'd0;
        send_cmd(c);
    endtask

    task automatic test_reads_and_unused();
        send_cmd(shaped_cmd(CMD_READ_BYTE, SCREEN_W - 1, SCREEN_PAGES - 2));
        send_cmd(shaped_cmd(CMD_READ_BYTE, -256, 15));
        send_cmd(random_cmd(CMD_UNUSED));
    endtask

    task automatic test_result_backpressure();
        draw_cmd_t c;
        cmd_idle_pct = 0;
        hold_request = 1'b1;
        for (int k = 0; k < 16; k++)
        begin
            if (k % 2 == 0)
            begin
                c = shaped_cmd(CMD_NATIVE_PIXEL, $urandom_range(7), $urandom_range(1));
                c.bit_req = 4'($urandom_range(7));
            end
            else
                c = shaped_cmd(CMD_READ_BYTE, $urandom_range(7), $urandom_range(1));
            send_cmd(c);
        end
        cmd_idle_pct = 36;
    endtask

    task automatic send_blit_run();
        draw_cmd_t c;
        int w, np, x0, p0, len, mode;
        w    = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
        np   = ($urandom_range(9) == 0) ? $urandom_range(15, 1) : $urandom_range(3, 1);
        x0   = ($urandom_range(1) == 0) ? $urandom_range(7) : int'($urandom_range(139)) - 8;
        p0   = ($urandom_range(1) == 0) ? $urandom_range(1) : int'($urandom_range(10)) - 2;
        len  = w * np;
        mode = $urandom_range(9);
        if (mode == 0)
            len = $urandom_range(len, 1);
        else if (mode == 1)
            len = len + $urandom_range(w, 1);
        for (int k = 0; k < len; k++)
        begin
            c = shaped_cmd(CMD_BLIT_BYTE, x0, p0);
            c.width = 8'(w);
            c.pages = 4'(np);
            c.first = (k == 0 && mode != 2);
            if (mode == 3 && k == len / 2)
            begin
                if ($urandom_range(1) == 0)
                    c.width = 8'd0;
                else
                    c.pages = 4'd0;
            end
            send_cmd(c);
        end
    endtask

    task automatic test_random_traffic(input int count);
        draw_cmd_t c;
        int target, r, s;
        target = items_sent + count;
        while (items_sent < target)
        begin
            r = $urandom_range(99);
            s = $urandom_range(9);
            if (r < 18)
            begin
                c = random_cmd(CMD_VISUAL_PIXEL);
                if (s < 5)
                begin
                    c.x = 9'(SCREEN_W - 8 + $urandom_range(7));
                    c.y = 8'(SCREEN_H - 16 + $urandom_range(15));
                end
                else if (s < 8)
                begin
                    c.x = 9'($urandom_range(SCREEN_W - 1));
                    c.y = 8'($urandom_range(SCREEN_H - 1));
                end
                send_cmd(c);
            end
            else if (r < 36)
            begin
                c = random_cmd(CMD_NATIVE_PIXEL);
                if (s < 5)
                begin
                    c.x = 9'($urandom_range(7));
                    c.page = 5'($urandom_range(1));
                    c.bit_req = 4'($urandom_range(7));
                end
                else if (s < 8)
                begin
                    c.x = 9'($urandom_range(SCREEN_W - 1));
                    c.page = 5'($urandom_range(SCREEN_PAGES - 1));
                    c.bit_req = 4'($urandom_range(7));
                end
                send_cmd(c);
            end
            else if (r < 56)
            begin
                c = random_cmd(CMD_READ_BYTE);
                if (s < 6)
                begin
                    c.x = 9'($urandom_range(7));
                    c.page = 5'($urandom_range(1));
                end
                else if (s < 9)
                begin
                    c.x = 9'($urandom_range(SCREEN_W - 1));
                    c.page = 5'($urandom_range(SCREEN_PAGES - 1));
                end
                send_cmd(c);
            end
            else if (r < 78)
                send_blit_run();
            else if (r < 92)
            begin
                c = random_cmd(CMD_CLEAR_RECT);
                if (s < 5)
                begin
                    c.x = 9'($urandom_range(7));
                    c.page = 5'($urandom_range(1));
                    c.width = 8'($urandom_range(4, 1));
                    c.pages = 4'($urandom_range(2, 1));
                end
                else if (s < 9)
                begin
                    c.x = 9'(int'($urandom_range(139)) - 10);
                    c.page = 5'(int'($urandom_range(11)) - 2);
                    c.width = 8'($urandom_range(12, 1));
                    c.pages = 4'($urandom_range(3, 1));
                end
                send_cmd(c);
            end
            else if (r < 94)
                send_cmd(random_cmd(CMD_FILL));
            else if (r < 96)
                send_cmd(random_cmd(CMD_CLEAR));
            else
                send_cmd(random_cmd(CMD_UNUSED));
        end
    endtask

    initial
    begin
        foreach (pixel_store[i])
            pixel_store[i] = BYTE_ZEROS;
        blit_col = 0;
        blit_row = 0;
        cmd_if.valid   = 1'b0;
        cmd_if.cmd     = CMD_VISUAL_PIXEL;
        cmd_if.x       = '0;
        cmd_if.y       = '0;
        cmd_if.page    = '0;
        cmd_if.bit_req = '0;
        cmd_if.on      = 1'b0;
        cmd_if.width   = '0;
        cmd_if.pages   = '0;
        cmd_if.data    = '0;
        cmd_if.first   = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_fill_and_read();
        test_visual_pixels();
        test_native_pixels();
        test_clear_rect();
        test_blit_stream();
        test_reads_and_unused();
        test_result_backpressure();

        // back-to-back stretch, no idling on either side
        cmd_idle_pct = 0;
        rsp_idle_pct = 0;
        test_random_traffic(200);
        cmd_idle_pct = 36;
        rsp_idle_pct = 36;
        test_random_traffic(680);

        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ page_framebuffer_draw_engine.f @@
sv/pfde_pkg.sv
sv/pfde_cmd_if.sv
sv/pfde_rsp_if.sv
sv/pfde_ctrl.sv
sv/pfde_datapath.sv
sv/page_framebuffer_draw_engine.sv
tb/sv/page_framebuffer_draw_engine_test.sv
